[rtl/core/paged_rom_cache_fifo_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the paged ROM cache
// Shared helpers so assertions vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PAGED_ROM_CACHE_FIFO_UNIT_DEFINES_SVH
`define PAGED_ROM_CACHE_FIFO_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/prc_pkg.sv]
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants of the paged ROM cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package prc_pkg;
    localparam int PageBytesDef = 512;
    localparam int SlotsDef     = 16;
    localparam int MapPagesDef  = 65536;

    typedef enum logic [1:0] {
        K_MAP  = 2'd0,
        K_READ = 2'd1,
        K_FILL = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        R_DATA  = 2'd0,
        R_FETCH = 2'd1,
        R_ERROR = 2'd2,
        R_RSVD  = 2'd3
    } t_rkind;

    // front -> back command word
    typedef struct packed {
        t_kind       kind;
        logic [24:0] position;
        logic [1:0]  access_size;
        logic [15:0] page_index;
        logic [31:0] data;
    } t_cmd;
endpackage
`default_nettype wire

[rtl/core/prc_front.sv]
// ----------------------------------------------------------------------------
// prc_front
// Input stage: accepts words, aligns read positions and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "paged_rom_cache_fifo_unit_defines.svh"
module prc_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    output logic           o_full,
    input  wire  [1:0]     i_kind,
    input  wire  [24:0]    i_position,
    input  wire  [1:0]     i_access_size,
    input  wire  [15:0]    i_page_index,
    input  wire  [31:0]    i_sector_number,
    input  wire  [31:0]    i_fill_word,
    output prc_pkg::t_cmd  o_cmd,
    output logic           o_cmd_valid,
    input  wire            i_cmd_take
);
    import prc_pkg::*;

    // two-entry command queue
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       w_push, w_pop;

    always_comb begin
        n_cmd.kind        = t_kind'(i_kind);
        n_cmd.access_size = i_access_size;
        n_cmd.page_index  = i_page_index;
        n_cmd.data        = (t_kind'(i_kind) == K_MAP) ? i_sector_number : i_fill_word;
        n_cmd.position    = i_position;
        if (i_access_size == 2'd1) begin
            n_cmd.position[0] = 1'b0;
        end else if (i_access_size[1]) begin
            n_cmd.position[1:0] = 2'b00;
        end
    end

    assign o_full      = r_cnt[1];
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    `PRC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'd2, !w_push)
    `PRC_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `PRC_ASSERT_NXT(a_pop_drops, i_clk, i_rst_n, w_pop && !w_push, r_cnt == $past(r_cnt) - 2'd1)
endmodule
`default_nettype wire

[rtl/core/prc_back.sv]
// ----------------------------------------------------------------------------
// prc_back
// Cache engine: tables, slot data memory, miss/fill sequencing, result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "paged_rom_cache_fifo_unit_defines.svh"
module prc_back #(
    parameter int PAGE_BYTES = prc_pkg::PageBytesDef,
    parameter int SLOTS      = prc_pkg::SlotsDef,
    parameter int MAP_PAGES  = prc_pkg::MapPagesDef
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  prc_pkg::t_cmd  i_cmd,
    input  wire            i_cmd_valid,
    output logic           o_cmd_take,
    output logic           o_empty,
    input  wire            i_pop,
    output logic [1:0]     o_result_kind,
    output logic [31:0]    o_read_data,
    output logic [31:0]    o_fetch_sector
);
    import prc_pkg::*;

    localparam int PageWords = PAGE_BYTES / 4;
    localparam int WW  = $clog2(PageWords);
    localparam int SW  = $clog2(SLOTS);
    localparam int MW  = $clog2(MAP_PAGES);
    localparam int OB  = $clog2(PAGE_BYTES);
    localparam int CW  = WW + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_EVICT = 5'b00100,
        S_RDAT  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    logic [31:0]   r_smap [MAP_PAGES];
    logic [SW-1:0] r_pslot [MAP_PAGES];
    logic          r_pres [MAP_PAGES];
    logic [MW-1:0] r_owner [SLOTS];
    logic [SLOTS-1:0] r_occ;
    logic [31:0]   r_data [SLOTS*PageWords];

    // residency clear pass
    logic [MW:0]   r_clr;
    logic          w_clearing;

    t_state        r_state;
    t_cmd          r_cmd;
    logic [SW-1:0] r_victim;
    logic          r_miss;
    logic [24:0]   r_ppos;
    logic [1:0]    r_psize;
    logic [SW-1:0] r_pslot_q;
    logic [CW-1:0] r_fcnt;
    logic [31:0]   r_smap_rd;
    logic [SW-1:0] r_pslot_rd;
    logic          r_pres_rd;
    logic [31:0]   r_word_rd;
    logic [24:0]   r_xpos;
    logic [1:0]    r_xsize;
    // staging result, then the output register
    logic          r_svalid;
    t_rkind        r_skind;
    logic [31:0]   r_sdata, r_ssec;
    logic          r_ovalid;
    t_rkind        r_okind;
    logic [31:0]   r_odata, r_osec;

    logic [24:0]   w_lpos;
    logic [MW-1:0] w_page;
    logic [WW-1:0] w_widx;
    logic [SW+WW-1:0] w_raddr;
    logic [31:0]   w_shift, w_ext;

    assign w_clearing = !r_clr[MW];
    // table lookups start on the take edge, so address them from the incoming command
    assign w_lpos  = (r_state == S_IDLE) ? i_cmd.position : r_cmd.position;
    assign w_page  = MW'(w_lpos >> OB);
    assign o_cmd_take = (r_state == S_IDLE) && !w_clearing && !r_svalid;
    assign o_empty = !r_ovalid;
    assign o_result_kind  = r_okind;
    assign o_read_data    = r_odata;
    assign o_fetch_sector = r_osec;

    assign w_widx  = WW'(r_xpos[OB-1:2]);
    assign w_shift = r_word_rd >> {r_xpos[1:0], 3'b000};
    always_comb begin
        case (r_xsize)
            2'd0:    w_ext = {24'd0, w_shift[7:0]};
            2'd1:    w_ext = {16'd0, w_shift[15:0]};
            default: w_ext = w_shift;
        endcase
    end

    // memory ports (registered reads)
    always_ff @(posedge i_clk) begin
        r_smap_rd  <= r_smap[w_page];
        r_pslot_rd <= r_pslot[w_page];
        if (r_state == S_IDLE && i_cmd_valid && o_cmd_take && i_cmd.kind == K_MAP
            && (32'(i_cmd.page_index) < 32'(MAP_PAGES))) begin
            r_smap[MW'(i_cmd.page_index)] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVICT) begin
            r_pslot[w_page] <= r_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pres_rd <= r_pres[w_page];
        if (w_clearing) begin
            r_pres[r_clr[MW-1:0]] <= 1'b0;
        end else if (r_state == S_LOOK && !r_pres_rd && r_occ[r_victim]) begin
            r_pres[r_owner[r_victim]] <= 1'b0;
        end else if (r_state == S_EVICT) begin
            r_pres[w_page] <= 1'b1;
        end
    end

    assign w_raddr = {r_pslot_q, w_widx};
    always_ff @(posedge i_clk) begin
        r_word_rd <= r_data[(r_state == S_LOOK) ? {r_pslot_rd, w_widx} : w_raddr];
        if (r_state == S_IDLE && i_cmd_valid && o_cmd_take && i_cmd.kind == K_FILL
            && r_miss) begin
            r_data[{r_pslot_q, r_fcnt[WW-1:0]}] <= i_cmd.data;
        end
        if (r_state == S_EVICT) begin
            r_owner[r_victim] <= w_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid && o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_IDLE && i_cmd_valid && o_cmd_take) begin
            r_xpos  <= (i_cmd.kind == K_READ) ? i_cmd.position : r_ppos;
            r_xsize <= (i_cmd.kind == K_READ) ? i_cmd.access_size : r_psize;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_clr    <= '0;
            r_occ    <= '0;
            r_victim <= '0;
            r_miss   <= 1'b0;
            r_fcnt   <= '0;
            r_ppos   <= '0;
            r_psize  <= '0;
            r_pslot_q <= '0;
            r_svalid <= 1'b0;
            r_skind  <= R_DATA;
            r_sdata  <= '0;
            r_ssec   <= '0;
            r_ovalid <= 1'b0;
            r_okind  <= R_DATA;
            r_odata  <= '0;
            r_osec   <= '0;
        end else begin
            if (w_clearing) r_clr <= r_clr + 1'b1;
            // staging word moves on when the output register is free or popped
            if (r_svalid && (!r_ovalid || i_pop)) begin
                r_svalid <= 1'b0;
                r_ovalid <= 1'b1;
                r_okind  <= r_skind;
                r_odata  <= r_sdata;
                r_osec   <= r_ssec;
            end else if (r_ovalid && i_pop) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && o_cmd_take) begin
                        case (i_cmd.kind)
                            K_READ: begin
                                if (r_miss) begin
                                    r_svalid <= 1'b1;
                                    r_skind  <= R_ERROR;
                                    r_sdata  <= '0;
                                    r_ssec   <= '0;
                                end else begin
                                    r_state <= S_LOOK;
                                end
                            end
                            K_FILL: begin
                                if (!r_miss) begin
                                    r_svalid <= 1'b1;
                                    r_skind  <= R_ERROR;
                                    r_sdata  <= '0;
                                    r_ssec   <= '0;
                                end else if (r_fcnt == CW'(PageWords - 1)) begin
                                    r_fcnt  <= '0;
                                    r_miss  <= 1'b0;
                                    r_state <= S_RDAT;
                                end else begin
                                    r_fcnt <= r_fcnt + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOOK: begin
                    if (r_pres_rd) begin
                        // no miss is pending here, so the slot register is free
                        r_pslot_q <= r_pslot_rd;
                        r_state   <= S_RDAT;
                    end else begin
                        r_state <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    r_occ[r_victim] <= 1'b1;
                    r_pslot_q <= r_victim;
                    r_victim  <= (32'(r_victim) == SLOTS - 1) ? '0 : r_victim + 1'b1;
                    r_miss    <= 1'b1;
                    r_ppos    <= r_cmd.position;
                    r_psize   <= r_cmd.access_size;
                    r_fcnt    <= '0;
                    r_svalid  <= 1'b1;
                    r_skind   <= R_FETCH;
                    r_sdata   <= '0;
                    r_ssec    <= r_smap_rd;
                    r_state   <= S_IDLE;
                end
                S_RDAT: begin
                    // read word is in r_word_rd after this cycle
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_svalid <= 1'b1;
                    r_skind  <= R_DATA;
                    r_sdata  <= w_ext;
                    r_ssec   <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PRC_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, o_cmd_take, r_state == S_IDLE)
    `PRC_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `PRC_ASSERT_NXT(a_evict_fetch, i_clk, i_rst_n, r_state == S_EVICT, r_svalid && r_skind == R_FETCH && r_miss)
    `PRC_ASSERT_IMP(a_fcnt, i_clk, i_rst_n, !r_miss, r_fcnt == '0)
endmodule
`default_nettype wire

[rtl/core/paged_rom_cache_fifo_unit.sv]
// To the result ports: a hit read runs through LOOK, RDAT and OUT, a fetch request
// through LOOK and EVICT, data after the last fill word through RDAT and OUT, an
// error word straight to staging; each result then passes the staging word and the
// output register. Map and plain fill words leave the engine in IDLE; all words wait
// longer while both result registers hold unpopped words. Reset: synchronous, active
// low; the residency table is swept clear, one entry a cycle, before any word is taken.
// ----------------------------------------------------------------------------
// paged_rom_cache_fifo_unit
// Fully associative page cache with FIFO replacement in front of sectors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module paged_rom_cache_fifo_unit #(
    parameter int PAGE_BYTES = prc_pkg::PageBytesDef,
    parameter int SLOTS      = prc_pkg::SlotsDef,
    parameter int MAP_PAGES  = prc_pkg::MapPagesDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [1:0]  i_kind,
    input  wire  [24:0] i_position,
    input  wire  [1:0]  i_access_size,
    input  wire  [15:0] i_page_index,
    input  wire  [31:0] i_sector_number,
    input  wire  [31:0] i_fill_word,
    output logic        empty,
    input  wire         pop,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_read_data,
    output logic [31:0] o_fetch_sector
);
    import prc_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_take;

    // front: takes words and aligns reads into a small queue
    prc_front u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .o_full(full),
        .i_kind, .i_position, .i_access_size, .i_page_index,
        .i_sector_number, .i_fill_word,
        .o_cmd(w_cmd), .o_cmd_valid(w_cmd_valid), .i_cmd_take(w_cmd_take)
    );

    // back: lookup, eviction, fill, then a staging word and the output register,
    // so one waiting result does not hold up the next command
    prc_back #(
        .PAGE_BYTES(PAGE_BYTES), .SLOTS(SLOTS), .MAP_PAGES(MAP_PAGES)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_cmd(w_cmd), .i_cmd_valid(w_cmd_valid), .o_cmd_take(w_cmd_take),
        .o_empty(empty), .i_pop(pop),
        .o_result_kind, .o_read_data, .o_fetch_sector
    );
endmodule
`default_nettype wire

[verif/tb_paged_rom_cache_fifo_unit.sv]
// ----------------------------------------------------------------------------
// tb_paged_rom_cache_fifo_unit
// Drives map, read and fill words into the page cache and checks every result
// word against an in-bench cache predictor (FIFO slot replacement).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_paged_rom_cache_fifo_unit;
    import prc_pkg::*;

    localparam int PageBytes = PageBytesDef;
    localparam int PageWords = PageBytes / 4;
    localparam int NumSlots  = SlotsDef;
    localparam int MapPages  = MapPagesDef;
    // Post-reset residency sweep dominates; keep well above it.
    localparam int WatchLimit = 4 * MapPages;
    localparam int DrainCycles = 20;
    localparam int HoldCycles  = 300;

    typedef struct packed {
        t_rkind      rkind;
        logic [31:0] rdata;
        logic [31:0] sector;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    wire         full;
    logic [1:0]  i_kind;
    logic [24:0] i_position;
    logic [1:0]  i_access_size;
    logic [15:0] i_page_index;
    logic [31:0] i_sector_number;
    logic [31:0] i_fill_word;
    wire         empty;
    logic        pop;
    wire  [1:0]  o_result_kind;
    wire  [31:0] o_read_data;
    wire  [31:0] o_fetch_sector;

    paged_rom_cache_fifo_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_position     (i_position),
        .i_access_size  (i_access_size),
        .i_page_index   (i_page_index),
        .i_sector_number(i_sector_number),
        .i_fill_word    (i_fill_word),
        .empty          (empty),
        .pop            (pop),
        .o_result_kind  (o_result_kind),
        .o_read_data    (o_read_data),
        .o_fetch_sector (o_fetch_sector)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ---------------- predictor state ----------------
    logic [31:0] sector_tbl [MapPages];
    bit          sector_set [MapPages];
    bit          resident   [MapPages];
    logic [3:0]  page_to_slot [MapPages];
    logic [15:0] slot_page  [NumSlots];
    bit          slot_used  [NumSlots];
    logic [31:0] page_store [NumSlots * PageWords];
    int          victim_ptr;
    bit          fetch_open;
    logic [24:0] open_pos;
    logic [1:0]  open_size;
    int          fills_seen;

    t_result expected_q[$];
    int      n_mismatch;
    int      send_idle_pct;
    int      recv_idle_pct;
    event    hold_go;       // starts a long receiver hold-off
    bit      hold_on;
    int      idle_cnt;

    // Aligned little-endian extraction from a cached page.
    function automatic logic [31:0] slice_word(int slot, logic [24:0] pos, logic [1:0] sz);
        int          off;
        logic [31:0] w;
        off = pos % PageBytes;
        w = page_store[slot * PageWords + off / 4] >> (8 * (off & 3));
        case (sz)
            2'd0:    return {24'd0, w[7:0]};
            2'd1:    return {16'd0, w[15:0]};
            default: return w;
        endcase
    endfunction

    task automatic predict_word(t_kind kind, logic [24:0] pos, logic [1:0] sz,
                                logic [15:0] pidx, logic [31:0] sec, logic [31:0] fw);
        t_result     r;
        logic [24:0] apos;
        int          page;
        int          v;
        r = '0;
        case (kind)
            K_MAP: begin
                sector_tbl[pidx] = sec;
                sector_set[pidx] = 1;
            end
            K_READ: begin
                apos = (sz == 2'd1) ? {pos[24:1], 1'b0}
                     : (sz >= 2'd2) ? {pos[24:2], 2'b00} : pos;
                page = (apos / PageBytes) % MapPages;
                if (fetch_open) begin
                    r.rkind = R_ERROR;
                end else if (resident[page]) begin
                    r.rkind = R_DATA;
                    r.rdata = slice_word(int'(page_to_slot[page]), apos, sz);
                end else begin
                    v = victim_ptr;
                    if (slot_used[v]) resident[slot_page[v]] = 0;
                    slot_page[v] = 16'(page);
                    slot_used[v] = 1;
                    page_to_slot[page] = 4'(v);
                    resident[page] = 1;
                    victim_ptr = (v + 1) % NumSlots;
                    fetch_open = 1;
                    open_pos = apos;
                    open_size = sz;
                    fills_seen = 0;
                    r.rkind = R_FETCH;
                    r.sector = sector_tbl[page];
                end
                expected_q.push_back(r);
            end
            K_FILL: begin
                if (!fetch_open) begin
                    r.rkind = R_ERROR;
                    expected_q.push_back(r);
                end else begin
                    page = (open_pos / PageBytes) % MapPages;
                    page_store[int'(page_to_slot[page]) * PageWords + fills_seen] = fw;
                    fills_seen++;
                    if (fills_seen == PageWords) begin
                        fetch_open = 0;
                        fills_seen = 0;
                        r.rkind = R_DATA;
                        r.rdata = slice_word(int'(page_to_slot[page]), open_pos, open_size);
                        expected_q.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Push one word; predicted when accepted. push stays high between back-to-back words.
    task automatic send_word(t_kind kind, logic [24:0] pos, logic [1:0] sz,
                             logic [15:0] pidx, logic [31:0] sec, logic [31:0] fw);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_kind          <= kind;
        i_position      <= pos;
        i_access_size   <= sz;
        i_page_index    <= pidx;
        i_sector_number <= sec;
        i_fill_word     <= fw;
        do @(posedge i_clk); while (full);
        predict_word(kind, pos, sz, pidx, sec, fw);
    endtask

    // Map a page before it is read so a miss never fetches an unwritten entry.
    task automatic map_page(int page);
        send_word(K_MAP, '0, '0, page[15:0], $urandom, $urandom);
    endtask

    // Read with the page mapped first; on a miss, supply the whole page.
    task automatic read_at(logic [24:0] pos, logic [1:0] sz);
        int page;
        page = (pos / PageBytes) % MapPages;
        if (!sector_set[page]) map_page(page);
        send_word(K_READ, pos, sz, 16'($urandom), $urandom, $urandom);
        if (fetch_open)
            for (int k = 0; k < PageWords; k++) begin
                // occasional map write mid-fill; gives no result
                if ($urandom_range(15) == 0) map_page($urandom_range(MapPages - 1));
                send_word(K_FILL, 25'($urandom), 2'($urandom), 16'($urandom),
                          $urandom, $urandom);
            end
    endtask

    // Positions in pages that are resident now, so random reads hit and cost one word.
    function automatic logic [24:0] pool_pos();
        int          v;
        logic [24:0] p;
        p = 25'($urandom);
        v = $urandom_range(NumSlots - 1);
        for (int k = 0; k < NumSlots && !slot_used[v]; k++) v = (v + 1) % NumSlots;
        if (slot_used[v])
            p = 25'(int'(slot_page[v]) * PageBytes + int'(p % PageBytes));
        return p;
    endfunction

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && pop && !empty) begin
            got.rkind  = t_rkind'(o_result_kind);
            got.rdata  = o_read_data;
            got.sector = o_fetch_sector;
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result word kind=%0d data=%h sector=%h",
                             got.rkind, got.rdata, got.sector);
            end else begin
                want = expected_q.pop_front();
                if (got != want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp k=%0d d=%h s=%h, got k=%0d d=%h s=%h",
                                 want.rkind, want.rdata, want.sector,
                                 got.rkind, got.rdata, got.sector);
                end
            end
        end
    end

    // Long receiver hold-off, counted here once requested.
    always begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Receiver: random pop, nothing while a hold-off runs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_on) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WatchLimit) begin
                $display("tb_paged_rom_cache_fifo_unit: FAIL");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        // stray fill before any miss
        send_word(K_FILL, '0, '0, '0, '0, 32'hFFFF_FFFF);
        // map extremes; out-of-range index impossible at 16 bits
        send_word(K_MAP, '0, '0, 16'hFFFF, 32'hFFFF_FFFF, '0);
        send_word(K_MAP, '0, '0, 16'h0000, 32'h0000_0000, '0);
        send_word(K_NONE, '1, '1, '1, '1, '1);   // ignored kind
        read_at(25'd3, 2'd0);                    // miss on page 0, byte
        read_at(25'd3, 2'd1);                    // halfword alignment
        read_at(25'd3, 2'd2);                    // word alignment
        read_at(25'd7, 2'd3);                    // size three reads a word
        // miss on the top page, a read while it is pending, then the fill
        send_word(K_READ, 25'h1FF_FFFF, 2'd0, '0, '0, '0);
        send_word(K_READ, 25'd0, 2'd0, '0, '0, '0);
        for (int k = 0; k < PageWords; k++)
            send_word(K_FILL, '0, '0, '0, '0, $urandom);
        read_at(25'h1FF_FFFE, 2'd1);             // hit on the top page
        wait_drained();
    endtask

    task automatic test_random(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 75) read_at(pool_pos(), 2'($urandom));
            else if (pick < 85) map_page($urandom_range(MapPages - 1));
            else if (pick < 92) send_word(K_FILL, 25'($urandom), 2'($urandom),
                                          16'($urandom), $urandom, $urandom);  // stray
            else send_word(K_NONE, 25'($urandom), 2'($urandom), 16'($urandom),
                           $urandom, $urandom);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        -> hold_go;
        for (int i = 0; i < 60; i++)
            read_at(pool_pos(), 2'($urandom));
        wait_drained();
    endtask

    initial begin
        push = 0;
        i_kind = '0; i_position = '0; i_access_size = '0;
        i_page_index = '0; i_sector_number = '0; i_fill_word = '0;
        victim_ptr = 0; fetch_open = 0; open_pos = '0; open_size = '0; fills_seen = 0;
        foreach (resident[i]) begin
            resident[i] = 0;
            sector_set[i] = 0;
        end
        foreach (slot_used[i]) slot_used[i] = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        i_rst_n = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        test_directed();
        send_idle_pct = 23; recv_idle_pct = 68;
        test_random(100);
        send_idle_pct = 68; recv_idle_pct = 23;
        test_random(100);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(100);

        if (n_mismatch == 0 && expected_q.size() == 0)
            $display("tb_paged_rom_cache_fifo_unit: PASS");
        else
            $display("tb_paged_rom_cache_fifo_unit: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
